[rtl/ghp_pkg.sv]
`timescale 1ns / 1ps

package ghp_pkg;

  // Pool geometry
  localparam int SLOTS     = 64;
  localparam int IDX_BITS  = $clog2(SLOTS);
  localparam int CNT_BITS  = $clog2(SLOTS + 1);
  localparam int GEN_BITS  = 8;
  localparam int DATA_BITS = 32;
  localparam int ACT_BITS  = 3;
  localparam int STAT_BITS = 2;

  // Command codes
  localparam logic [ACT_BITS-1:0] ACT_CREATE  = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_DESTROY = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_WRITE   = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_READ    = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_CHECK   = 3'd4;

  // Status codes
  localparam logic [STAT_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [ACT_BITS-1:0]         action;
    logic [IDX_BITS-1:0]         handle_index;
    logic [GEN_BITS-1:0]         handle_generation;
    logic signed [DATA_BITS-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]        status;
    logic                        is_valid;
    logic [IDX_BITS-1:0]         new_index;
    logic [GEN_BITS-1:0]         new_generation;
    logic signed [DATA_BITS-1:0] read_value;
  } rsp_t;

  // Free stack entry: a freed slot carries its next generation along
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [GEN_BITS-1:0] gen;
  } stk_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    stk_entry_t entry;
  } stk_ctrl_t;

endpackage

[rtl/generational_handle_pool.sv]
`timescale 1ns / 1ps

// Generational handle pool over 64 slots. A command is taken on any clock edge
// with start high; busy never rises, so a command may be issued every cycle.
// The result register loads on the edge after the command's transfer. The
// result is then on rsp_o with done_o high for exactly one cycle. Results come
// in command order; the receiver cannot stall them and must take each one in
// its cycle. The slot generation and slot data tables are memories with one
// write port and one registered read port. Each is read ahead at the incoming
// command's index, with forwarding from the command in flight. The free stack
// stores each freed slot together with its next generation and keeps its top
// prefetched. No clearing pass follows reset: live and generation state come
// up zero at once.
module generational_handle_pool (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ghp_pkg::cmd_t cmd_i,
  output logic          done_o,
  output ghp_pkg::rsp_t rsp_o
);
  import ghp_pkg::*;

  // Command register
  cmd_t                 req_q;
  logic                 req_vld_q;

  // Per-slot flags
  logic [SLOTS-1:0]     live_q, live_d;
  logic [SLOTS-1:0]     gen_set_q, gen_set_d;
  logic [CNT_BITS-1:0]  fresh_q, fresh_d;

  // Generation table
  logic [GEN_BITS-1:0]  gen_mem [SLOTS];
  logic [GEN_BITS-1:0]  gen_rd_q, gen_bypd_q, gen_cur, gen_next;
  logic                 gen_byp_q, gen_we;

  // Data table
  logic [DATA_BITS-1:0] val_mem [SLOTS];
  logic [DATA_BITS-1:0] val_rd_q, val_bypd_q, val_cur, val_wdata;
  logic [IDX_BITS-1:0]  val_waddr;
  logic                 val_byp_q, val_we;

  // Free stack
  stk_ctrl_t            stk_ctrl;
  stk_entry_t           stk_top;
  logic                 stk_empty;

  // Result register
  rsp_t                 rsp_d, rsp_q;
  logic                 done_q;

  logic [IDX_BITS-1:0]  hidx;
  logic                 hit;
  logic                 got;
  logic [IDX_BITS-1:0]  slot;
  logic [GEN_BITS-1:0]  slot_gen;

  assign busy = 1'b0;

  ghp_free_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .top_o   (stk_top),
    .empty_o (stk_empty)
  );

  // Handle test against current slot state
  assign hidx     = req_q.handle_index;
  assign gen_cur  = gen_byp_q ? gen_bypd_q : (gen_set_q[hidx] ? gen_rd_q : '0);
  assign val_cur  = val_byp_q ? val_bypd_q : val_rd_q;
  assign hit      = live_q[hidx] && (gen_cur == req_q.handle_generation);
  assign gen_next = GEN_BITS'(gen_cur + 1'b1);

  // Command execution
  always_comb begin
    rsp_d     = '0;
    live_d    = live_q;
    gen_set_d = gen_set_q;
    fresh_d   = fresh_q;
    gen_we    = 1'b0;
    val_we    = 1'b0;
    val_waddr = hidx;
    val_wdata = req_q.write_value;
    stk_ctrl  = '0;
    stk_ctrl.entry.idx = hidx;
    stk_ctrl.entry.gen = gen_next;
    got       = 1'b0;
    slot      = '0;
    slot_gen  = '0;
    if (req_vld_q) begin
      case (req_q.action) inside
        ACT_CREATE: begin
          if (!stk_empty) begin
            got          = 1'b1;
            slot         = stk_top.idx;
            slot_gen     = stk_top.gen;
            stk_ctrl.pop = 1'b1;
          end else if (fresh_q < CNT_BITS'(SLOTS)) begin
            // never-used slot: generation still zero
            got     = 1'b1;
            slot    = fresh_q[IDX_BITS-1:0];
            fresh_d = CNT_BITS'(fresh_q + 1'b1);
          end
          if (got) begin
            live_d[slot]         = 1'b1;
            val_we               = 1'b1;
            val_waddr            = slot;
            val_wdata            = '0;
            rsp_d.is_valid       = 1'b1;
            rsp_d.new_index      = slot;
            rsp_d.new_generation = slot_gen;
          end else begin
            rsp_d.status = ST_FULL;
          end
        end
        ACT_DESTROY, ACT_WRITE, ACT_READ, ACT_CHECK: begin
          if (!hit) begin
            rsp_d.status = ST_INVALID;
          end else begin
            rsp_d.is_valid = 1'b1;
            case (req_q.action)
              ACT_DESTROY: begin
                gen_we          = 1'b1;
                gen_set_d[hidx] = 1'b1;
                live_d[hidx]    = 1'b0;
                stk_ctrl.push   = 1'b1;
              end
              ACT_WRITE: begin
                val_we = 1'b1;
              end
              ACT_READ: begin
                rsp_d.read_value = val_cur;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          rsp_d.status = ST_INVALID;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      done_q    <= 1'b0;
      live_q    <= '0;
      gen_set_q <= '0;
      fresh_q   <= '0;
    end else begin
      req_vld_q <= start && !busy;
      done_q    <= req_vld_q;
      live_q    <= live_d;
      gen_set_q <= gen_set_d;
      fresh_q   <= fresh_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= cmd_i;
    end
    rsp_q <= rsp_d;
  end

  // Generation table: write by destroy, read ahead at the incoming index
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[hidx] <= gen_next;
    end
    gen_rd_q   <= gen_mem[cmd_i.handle_index];
    gen_byp_q  <= gen_we && (hidx == cmd_i.handle_index);
    gen_bypd_q <= gen_next;
  end

  // Data table: write by create (clear) and write, read ahead likewise
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rd_q   <= val_mem[cmd_i.handle_index];
    val_byp_q  <= val_we && (val_waddr == cmd_i.handle_index);
    val_bypd_q <= val_wdata;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[rtl/ghp_free_stack.sv]
`timescale 1ns / 1ps

module ghp_free_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ghp_pkg::stk_ctrl_t  ctrl_i,
  output ghp_pkg::stk_entry_t top_o,
  output logic                empty_o
);
  import ghp_pkg::*;

  stk_entry_t          mem [SLOTS];
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [IDX_BITS-1:0] waddr, raddr;
  logic                we;
  stk_entry_t          rd_q, bypd_q;
  logic                byp_q;

  // Fill level update
  always_comb begin
    count_d = count_q;
    we      = 1'b0;
    if (ctrl_i.pop && count_q != '0) begin
      count_d = CNT_BITS'(count_q - 1'b1);
    end else if (ctrl_i.push && count_q < CNT_BITS'(SLOTS)) begin
      count_d = CNT_BITS'(count_q + 1'b1);
      we      = 1'b1;
    end
  end

  assign waddr = count_q[IDX_BITS-1:0];
  // Prefetch the entry that will be on top after this cycle's transfer
  assign raddr = IDX_BITS'(count_d - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Storage, registered read, same-address forwarding
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= ctrl_i.entry;
    end
    rd_q   <= mem[raddr];
    byp_q  <= we && (waddr == raddr);
    bypd_q <= ctrl_i.entry;
  end

  assign top_o   = byp_q ? bypd_q : rd_q;
  assign empty_o = (count_q == '0);

endmodule

[rtl/ghp_checker.sv]
`timescale 1ns / 1ps

module ghp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input ghp_pkg::cmd_t cmd_i,
  input logic          done_o,
  input ghp_pkg::rsp_t rsp_o
);
  import ghp_pkg::*;

  // Every transfer in yields one result
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("missing result for accepted command");

  // No result without an earlier command transfer
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without command");

  // Pool full is only reported to a create, with all fields cleared
  a_full_create : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |->
      ($past(cmd_i.action, 2) == ACT_CREATE && !rsp_o.is_valid &&
       rsp_o.new_index == '0 && rsp_o.new_generation == '0))
    else $error("bad pool full result");

  // A failed command never reports a valid handle or data
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |->
      (!rsp_o.is_valid && rsp_o.read_value == '0))
    else $error("failed command carries data");

endmodule

bind generational_handle_pool ghp_checker u_ghp_checker (.*);

[verif/generational_handle_pool_tb.sv]
`timescale 1ns / 1ps

module generational_handle_pool_tb;
  import ghp_pkg::*;

  // Two copies of the pool state: one steers stimulus, one predicts at transfer
  localparam int PLAN = 0;
  localparam int LIVE = 1;
  localparam int WATCHDOG_LIMIT = 500;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_CHURN} phase_e;

  typedef struct packed {
    logic hold;  // wait for every outstanding result before issuing
    cmd_t cmd;
  } pend_item_t;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  cmd_t  cmd_i  = '0;
  logic  busy;
  logic  done_o;
  rsp_t  rsp_o;

  // Shadow pool state
  bit                 slot_live_m  [2][SLOTS];
  bit [GEN_BITS-1:0]  slot_gen_m   [2][SLOTS];
  bit [DATA_BITS-1:0] slot_data_m  [2][SLOTS];
  bit [IDX_BITS-1:0]  free_stk_m   [2][SLOTS];
  int unsigned        free_depth_m [2];
  int unsigned        fresh_next_m [2];

  pend_item_t pend_q[$];
  rsp_t       expected_rsp_q[$];
  rsp_t       pred_rsp;
  int         planned_n    = 0;
  int         accepted_n   = 0;
  int         results_seen = 0;
  int         mismatch_n   = 0;
  int         burst_left   = 0;
  int         gap_left     = 0;
  int         stall_cycles = 0;
  int         n_create_ok  = 0;
  int         n_full       = 0;
  int         n_invalid    = 0;
  int         n_read_ok    = 0;
  int         n_gen_wrap   = 0;

  generational_handle_pool u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Apply one command to shadow copy m and return the response it produces
  function automatic rsp_t pool_apply(input int m, input cmd_t c);
    rsp_t        r;
    int unsigned s;
    bit          got;
    int unsigned hi;
    r   = '0;
    s   = 0;
    got = 1'b0;
    hi  = c.handle_index;
    case (c.action) inside
      ACT_CREATE: begin
        // LIFO reuse first, then never-used slots
        if (free_depth_m[m] > 0) begin
          free_depth_m[m]--;
          s   = free_stk_m[m][free_depth_m[m]];
          got = 1'b1;
        end else if (fresh_next_m[m] < SLOTS) begin
          s = fresh_next_m[m];
          fresh_next_m[m]++;
          got = 1'b1;
        end
        if (got) begin
          slot_live_m[m][s] = 1'b1;
          slot_data_m[m][s] = '0;
          r.is_valid       = 1'b1;
          r.new_index      = s[IDX_BITS-1:0];
          r.new_generation = slot_gen_m[m][s];
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_DESTROY, ACT_WRITE, ACT_READ, ACT_CHECK: begin
        if (!(slot_live_m[m][hi] && slot_gen_m[m][hi] == c.handle_generation)) begin
          r.status = ST_INVALID;
        end else begin
          r.is_valid = 1'b1;
          case (c.action)
            ACT_DESTROY: begin
              slot_gen_m[m][hi]  = slot_gen_m[m][hi] + 1'b1;
              slot_live_m[m][hi] = 1'b0;
              if (free_depth_m[m] < SLOTS) begin
                free_stk_m[m][free_depth_m[m]] = c.handle_index;
                free_depth_m[m]++;
              end
            end
            ACT_WRITE: slot_data_m[m][hi] = c.write_value;
            ACT_READ:  r.read_value = slot_data_m[m][hi];
            default: ;
          endcase
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [ACT_BITS-1:0] a, input int unsigned idx,
                                  input int unsigned g, input logic [DATA_BITS-1:0] v);
    cmd_t c;
    c.action            = a;
    c.handle_index      = idx[IDX_BITS-1:0];
    c.handle_generation = g[GEN_BITS-1:0];
    c.write_value       = v;
    return c;
  endfunction

  // Queue a command and advance the steering copy
  function automatic rsp_t plan_push(input cmd_t c, input bit hold);
    pend_item_t p;
    p.hold = hold;
    p.cmd  = c;
    pend_q.insert(pend_q.size(), p);
    planned_n++;
    return pool_apply(PLAN, c);
  endfunction

  // Mostly random words, sometimes the extremes
  function automatic logic [DATA_BITS-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_BITS-1){1'b0}}};
      1: return {1'b0, {(DATA_BITS-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random live handle from the steering copy
  function automatic bit pick_live(output int unsigned idx, output int unsigned g);
    int unsigned base;
    base = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_live_m[PLAN][(base + k) % SLOTS]) begin
        idx = (base + k) % SLOTS;
        g   = slot_gen_m[PLAN][idx];
        return 1'b1;
      end
    end
    idx = 0;
    g   = 0;
    return 1'b0;
  endfunction

  // One stretch of random traffic with a given mix
  function automatic void plan_phase(input phase_e ph, input int n, input bit hold_first);
    int          pct;
    int          cut_create;
    int          cut_destroy;
    int          cut_write;
    int          cut_read;
    int          cut_check;
    int unsigned idx;
    int unsigned g;
    int          done_n;
    bit          hold;
    rsp_t        r;
    cmd_t        c;
    done_n = 0;
    hold   = hold_first;
    case (ph)
      PH_FILL:  begin cut_create = 55; cut_destroy = 63; cut_write = 78; cut_read = 90; end
      PH_DRAIN: begin cut_create = 8;  cut_destroy = 45; cut_write = 65; cut_read = 80; end
      default:  begin cut_create = 25; cut_destroy = 45; cut_write = 65; cut_read = 80; end
    endcase
    cut_check = cut_read + 9;
    while (done_n < n) begin
      if (ph == PH_CHURN) begin
        // Create and destroy the same slot over and over to wrap its generation
        r = plan_push(mk_cmd(ACT_CREATE, 0, 0, rand_word()), hold);
        hold   = 1'b0;
        done_n++;
        if (r.is_valid) begin
          if ($urandom_range(0, 3) == 0) begin
            void'(plan_push(mk_cmd(ACT_WRITE, r.new_index, r.new_generation, rand_word()), 0));
            void'(plan_push(mk_cmd(ACT_READ, r.new_index, r.new_generation, rand_word()), 0));
            done_n += 2;
          end
          void'(plan_push(mk_cmd(ACT_DESTROY, r.new_index, r.new_generation, rand_word()), 0));
          done_n++;
        end
      end else begin
        pct = $urandom_range(0, 99);
        if (pct >= cut_check) begin
          // Noise: stale generation on a live slot, or anything at all
          if ($urandom_range(0, 1) && pick_live(idx, g))
            c = mk_cmd(ACT_BITS'($urandom_range(ACT_DESTROY, ACT_CHECK)), idx,
                       g + $urandom_range(1, 255), rand_word());
          else
            c = mk_cmd(ACT_BITS'($urandom_range(0, 2**ACT_BITS - 1)),
                       $urandom_range(0, SLOTS - 1),
                       $urandom_range(0, 2**GEN_BITS - 1), $urandom);
        end else if (pct < cut_create || !pick_live(idx, g)) begin
          c = mk_cmd(ACT_CREATE, $urandom_range(0, SLOTS - 1), $urandom_range(0, 255),
                     rand_word());
        end else if (pct < cut_destroy) begin
          c = mk_cmd(ACT_DESTROY, idx, g, rand_word());
        end else if (pct < cut_write) begin
          c = mk_cmd(ACT_WRITE, idx, g, rand_word());
        end else if (pct < cut_read) begin
          c = mk_cmd(ACT_READ, idx, g, rand_word());
        end else begin
          c = mk_cmd(ACT_CHECK, idx, g, rand_word());
        end
        void'(plan_push(c, hold));
        hold = 1'b0;
        done_n++;
      end
    end
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_n++;
    end
  endtask

  task automatic pred_check(input rsp_t want);
    check_field("status", 64'(want.status), 64'(rsp_o.status));
    check_field("is_valid", 64'(want.is_valid), 64'(rsp_o.is_valid));
    check_field("new_index", 64'(want.new_index), 64'(rsp_o.new_index));
    check_field("new_generation", 64'(want.new_generation), 64'(rsp_o.new_generation));
    check_field("read_value", 64'(want.read_value), 64'(rsp_o.read_value));
  endtask

  // Driver: bursts with random gaps; a hold item waits for the pipeline to empty
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      cmd_i      <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        pred_rsp = pool_apply(LIVE, cmd_i);
        expected_rsp_q.insert(expected_rsp_q.size(), pred_rsp);
        accepted_n++;
        if (cmd_i.action == ACT_CREATE && pred_rsp.is_valid) n_create_ok++;
        if (pred_rsp.status == ST_FULL) n_full++;
        if (pred_rsp.status == ST_INVALID) n_invalid++;
        if (cmd_i.action == ACT_READ && pred_rsp.is_valid) n_read_ok++;
        if (cmd_i.action == ACT_DESTROY && pred_rsp.is_valid &&
            slot_gen_m[LIVE][cmd_i.handle_index] == '0) n_gen_wrap++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pend_q.size() == 0 || (pend_q[0].hold && accepted_n != results_seen)) begin
        start <= 1'b0;
      end else begin
        cmd_i <= pend_q[0].cmd;
        start <= 1'b1;
        void'(pend_q.pop_front());
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result strobed with no command outstanding");
        mismatch_n++;
      end else begin
        pred_check(expected_rsp_q.pop_front());
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: too long without any transfer in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", stall_cycles);
        $display("generational_handle_pool: mismatch");
        $finish;
      end
    end
  end

  initial begin
    // Directed: data extremes, stale handles, LIFO reuse, cleared data, unused codes
    void'(plan_push(mk_cmd(ACT_CREATE, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_WRITE, 0, 0, 32'h7fff_ffff), 0));
    void'(plan_push(mk_cmd(ACT_READ, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_WRITE, 0, 0, 32'h8000_0000), 0));
    void'(plan_push(mk_cmd(ACT_READ, 0, 0, '1), 0));
    void'(plan_push(mk_cmd(ACT_CHECK, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_CHECK, 0, 255, '0), 0));
    void'(plan_push(mk_cmd(ACT_CHECK, SLOTS - 1, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_DESTROY, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_DESTROY, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_READ, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_WRITE, 0, 0, '1), 0));
    void'(plan_push(mk_cmd(ACT_CREATE, SLOTS - 1, 255, '1), 0));
    void'(plan_push(mk_cmd(ACT_READ, 0, 1, '0), 0));
    void'(plan_push(mk_cmd(ACT_CREATE, 0, 0, '0), 0));
    for (int k = 1; k < 2**ACT_BITS - ACT_CHECK; k++)
      void'(plan_push(mk_cmd(ACT_BITS'(ACT_CHECK + k), SLOTS - 1, 255, '1), 0));
    void'(plan_push(mk_cmd(ACT_WRITE, 1, 0, '1), 0));
    void'(plan_push(mk_cmd(ACT_READ, 1, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_DESTROY, 1, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_DESTROY, 0, 1, '0), 0));
    void'(plan_push(mk_cmd(ACT_CREATE, 0, 0, '0), 0));
    void'(plan_push(mk_cmd(ACT_CREATE, 0, 0, '0), 0));

    // Random: fill to exhaustion, wrap generations, drain, mixed traffic
    plan_phase(PH_FILL, 300, 1'b1);
    plan_phase(PH_DRAIN, 350, $urandom_range(0, 1));
    plan_phase(PH_CHURN, 650, 1'b1);
    plan_phase(PH_MIXED, 350, $urandom_range(0, 1));
    plan_phase(PH_FILL, 200, $urandom_range(0, 1));
    plan_phase(PH_DRAIN, 200, 1'b1);

    // Reset once, then let the driver run
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_n == planned_n && results_seen == accepted_n);
    repeat (8) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d results never arrived", expected_rsp_q.size());
      mismatch_n++;
    end

    $display("%0d commands, %0d results: %0d creates, %0d pool-full, %0d rejected handles",
             accepted_n, results_seen, n_create_ok, n_full, n_invalid);
    $display("%0d valid reads, %0d generation wraps", n_read_ok, n_gen_wrap);
    if (mismatch_n == 0) begin
      $display("generational_handle_pool: match");
    end else begin
      $display("generational_handle_pool: mismatch");
    end
    $finish;
  end

endmodule
